FILE: rtl/core/poisson_disk_grid_sampler_top_defines.svh
// Assertion macros shared by the sampler RTL
`ifndef POISSON_DISK_GRID_SAMPLER_TOP_DEFINES_SVH
`define POISSON_DISK_GRID_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PDGS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdgs check failed");

// next-cycle implication, disabled in reset
`define PDGS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdgs check failed");

`endif

FILE: rtl/core/pdgs_pkg.sv
// Shared types, codes and constants of the grid sampler
package pdgs_pkg;

  localparam int DEF_GRID_DIM        = 16;
  localparam int DEF_NEIGHBOUR_REACH = 2;
  localparam int STORE_DEPTH         = 4096;
  localparam int PT_AW               = 12;
  localparam int CNT_W               = 13;
  localparam int COORD_W             = 16;
  localparam int RECIP_W             = 20;
  localparam int PROD_W              = COORD_W + RECIP_W;
  localparam int CELL_SHIFT          = 24;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 20;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_SEED    = 2'd1,
    KIND_CAND    = 2'd2,
    KIND_ADVANCE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_TOO_CLOSE = 3'd2,
    ST_TAKEN     = 3'd3,
    ST_NO_PARENT = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X      = 3'd0,
    REG_MIN_Y      = 3'd1,
    REG_MIN_Z      = 3'd2,
    REG_EXTENT_X   = 3'd3,
    REG_EXTENT_Y   = 3'd4,
    REG_EXTENT_Z   = 3'd5,
    REG_MIN_RADIUS = 3'd6,
    REG_CELL_RECIP = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_PARENT,
    S_AXIS0,
    S_AXIS1,
    S_EVAL,
    S_SCAN_ADDR,
    S_SCAN_CELL,
    S_SCAN_PT,
    S_SCAN_CMP,
    S_OWN_RD,
    S_OWN_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                       in_range;
    logic signed [COORD_W-1:0]  pos;
  } axis_info_t;

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_add = s[COORD_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/pdgs_ram.sv
// Simple dual-port synchronous RAM with registered read
module pdgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pdgs_axis.sv
// Per-axis flat forcing, extent check and cell index in two register stages
module pdgs_axis #(
  parameter int GRID_DIM = 16,
  parameter int CW       = 4,
  parameter int NW       = 5
) (
  input  logic                               clk,
  input  logic signed [pdgs_pkg::COORD_W-1:0] p,
  input  logic signed [pdgs_pkg::COORD_W-1:0] min_a,
  input  logic [pdgs_pkg::COORD_W-1:0]        extent,
  input  logic [pdgs_pkg::RECIP_W-1:0]        recip,
  output pdgs_pkg::axis_info_t               info,
  output logic [CW-1:0]                      idx,
  output logic [NW-1:0]                      cnt
);
  import pdgs_pkg::*;

  localparam int IDX_W = PROD_W - CELL_SHIFT;

  logic signed [COORD_W-1:0] pf;
  logic signed [COORD_W+1:0] hi;
  logic                      ins;
  logic [COORD_W-1:0]        diff;
  logic signed [COORD_W-1:0] pf_q;
  logic                      ins_q;
  logic [PROD_W-1:0]         dprod;
  logic [PROD_W-1:0]         eprod;
  logic [PROD_W:0]           nsum;
  logic [IDX_W:0]            nraw;
  logic [IDX_W:0]            nsat;
  logic [IDX_W-1:0]          iraw;
  logic [IDX_W:0]            iclamp;

  always_comb begin
    pf   = (extent == '0) ? min_a : p;
    hi   = {{2{min_a[COORD_W-1]}}, min_a} + {2'b00, extent};
    ins  = (pf >= min_a) && ($signed({{2{pf[COORD_W-1]}}, pf}) <= hi);
    diff = COORD_W'(pf - min_a);
  end

  always_ff @(posedge clk) begin
    pf_q  <= pf;
    ins_q <= ins;
    dprod <= PROD_W'(diff) * PROD_W'(recip);
    eprod <= PROD_W'(extent) * PROD_W'(recip);
  end

  always_comb begin
    nsum = {1'b0, eprod} + (PROD_W+1)'({CELL_SHIFT{1'b1}});
    nraw = nsum[PROD_W:CELL_SHIFT];
    if (nraw == '0) begin
      nsat = (IDX_W+1)'(1);
    end else if (nraw > (IDX_W+1)'(GRID_DIM)) begin
      nsat = (IDX_W+1)'(GRID_DIM);
    end else begin
      nsat = nraw;
    end
    iraw = dprod[PROD_W-1:CELL_SHIFT];
    if ({1'b0, iraw} >= nsat) begin
      iclamp = nsat - (IDX_W+1)'(1);
    end else begin
      iclamp = {1'b0, iraw};
    end
  end

  always_ff @(posedge clk) begin
    info.in_range <= ins_q;
    info.pos      <= pf_q;
    idx           <= iclamp[CW-1:0];
    cnt           <= nsat[NW-1:0];
  end

endmodule

FILE: rtl/core/poisson_disk_grid_sampler_top.sv
// Top level of the 3D Poisson disk grid sampler acceptance core
//
// channel  | handshake              | payload
// ---------+------------------------+----------------------------------------
// command  | start, busy            | kind, coord_x, coord_y, coord_z
// result   | done (one-cycle pulse) | status, point_index, pos_x/y/z,
//          |                        | point_total
// config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// Advance and parentless candidates go straight to done; seeds and candidates
// outside the extent end at the evaluation. A seed then checks its own cell; a
// candidate first reads its parent, then walks the neighbour cells: one off the
// grid is skipped, an empty one is read, an occupied one has its point compared,
// and a close point ends the walk early. Reset and the clear command sweep the
// cell table, busy high. Results cannot be stalled; done pulses once per command.
module poisson_disk_grid_sampler_top #(
  parameter int GRID_DIM        = pdgs_pkg::DEF_GRID_DIM,
  parameter int NEIGHBOUR_REACH = pdgs_pkg::DEF_NEIGHBOUR_REACH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           kind,
  input  logic signed [pdgs_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [pdgs_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [pdgs_pkg::COORD_W-1:0]  coord_z,
  output logic                                 done,
  output logic [2:0]                           status,
  output logic [pdgs_pkg::PT_AW-1:0]           point_index,
  output logic signed [pdgs_pkg::COORD_W-1:0]  pos_x,
  output logic signed [pdgs_pkg::COORD_W-1:0]  pos_y,
  output logic signed [pdgs_pkg::COORD_W-1:0]  pos_z,
  output logic [pdgs_pkg::CNT_W-1:0]           point_total,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pdgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pdgs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pdgs_pkg::*;
  `include "poisson_disk_grid_sampler_top_defines.svh"

  localparam int CW    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int NW    = $clog2(GRID_DIM + 1);
  localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int CAW   = $clog2(CELLS);
  localparam int SPAN  = 2 * NEIGHBOUR_REACH + 1;
  localparam int OW    = $clog2(SPAN);
  localparam int SW    = CW + OW + 2;
  localparam int PW    = 3 * COORD_W;

  logic signed [COORD_W-1:0] min_x, min_y, min_z;
  logic [COORD_W-1:0]        extent_x, extent_y, extent_z;
  logic [COORD_W-1:0]        min_radius;
  logic [RECIP_W-1:0]        cell_recip;
  logic [2*COORD_W-1:0]      r2;

  state_t state, state_next;
  logic                      clr_reply;
  kind_t                     kind_q;
  logic signed [COORD_W-1:0] off_x, off_y, off_z;
  logic signed [COORD_W-1:0] p_x, p_y, p_z;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          active;
  logic [CAW-1:0]            sweep;
  logic [OW-1:0]             ox, oy, oz;
  logic [2*COORD_W-1:0]      sq_x, sq_y, sq_z;
  status_t                   res_status;
  logic [PT_AW-1:0]          res_index;
  logic signed [COORD_W-1:0] res_x, res_y, res_z;

  axis_info_t   ax_info, ay_info, az_info;
  logic [CW-1:0] cx, cy, cz;
  logic [NW-1:0] nx, ny, nz;

  logic            cell_we;
  logic [CAW-1:0]  cell_waddr, cell_raddr;
  logic [CNT_W-1:0] cell_wdata, cell_rdata;
  logic            pt_we;
  logic [PT_AW-1:0] pt_waddr, pt_raddr;
  logic [PW-1:0]   pt_wdata, pt_rdata;

  logic signed [SW-1:0] ix, iy, iz;
  logic                 nb_ok, cell_hit, scan_last, no_parent, full;
  logic [CAW-1:0]       nb_addr, own_addr;
  logic [CNT_W-1:0]     hit_index;
  logic [2*COORD_W+1:0] dsum;
  logic signed [COORD_W:0] d_x, d_y, d_z;
  logic [COORD_W:0]     m_x, m_y, m_z;
  logic signed [COORD_W-1:0] st_x, st_y, st_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x      <= '0;
      min_y      <= '0;
      min_z      <= '0;
      extent_x   <= '0;
      extent_y   <= '0;
      extent_z   <= '0;
      min_radius <= COORD_W'(256);
      cell_recip <= RECIP_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_X:      min_x      <= cfg_data[COORD_W-1:0];
        REG_MIN_Y:      min_y      <= cfg_data[COORD_W-1:0];
        REG_MIN_Z:      min_z      <= cfg_data[COORD_W-1:0];
        REG_EXTENT_X:   extent_x   <= cfg_data[COORD_W-1:0];
        REG_EXTENT_Y:   extent_y   <= cfg_data[COORD_W-1:0];
        REG_EXTENT_Z:   extent_z   <= cfg_data[COORD_W-1:0];
        REG_MIN_RADIUS: min_radius <= cfg_data[COORD_W-1:0];
        REG_CELL_RECIP: cell_recip <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= (2*COORD_W)'(min_radius) * (2*COORD_W)'(min_radius);
  end

  pdgs_axis #(.GRID_DIM(GRID_DIM), .CW(CW), .NW(NW)) u_axis_x (
    .clk(clk), .p(p_x), .min_a(min_x), .extent(extent_x), .recip(cell_recip),
    .info(ax_info), .idx(cx), .cnt(nx)
  );
  pdgs_axis #(.GRID_DIM(GRID_DIM), .CW(CW), .NW(NW)) u_axis_y (
    .clk(clk), .p(p_y), .min_a(min_y), .extent(extent_y), .recip(cell_recip),
    .info(ay_info), .idx(cy), .cnt(ny)
  );
  pdgs_axis #(.GRID_DIM(GRID_DIM), .CW(CW), .NW(NW)) u_axis_z (
    .clk(clk), .p(p_z), .min_a(min_z), .extent(extent_z), .recip(cell_recip),
    .info(az_info), .idx(cz), .cnt(nz)
  );

  pdgs_ram #(.WIDTH(CNT_W), .DEPTH(CELLS), .AW(CAW)) u_cell_table (
    .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  pdgs_ram #(.WIDTH(PW), .DEPTH(STORE_DEPTH), .AW(PT_AW)) u_point_store (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  always_comb begin
    ix = $signed(SW'(cx)) + $signed(SW'(ox)) - $signed(SW'(NEIGHBOUR_REACH));
    iy = $signed(SW'(cy)) + $signed(SW'(oy)) - $signed(SW'(NEIGHBOUR_REACH));
    iz = $signed(SW'(cz)) + $signed(SW'(oz)) - $signed(SW'(NEIGHBOUR_REACH));
    nb_ok = (ix >= 0) && (ix < $signed(SW'(nx))) &&
            (iy >= 0) && (iy < $signed(SW'(ny))) &&
            (iz >= 0) && (iz < $signed(SW'(nz)));
    nb_addr = CAW'(CAW'(ix[CW-1:0]) * CAW'(GRID_DIM * GRID_DIM)
            + CAW'(iy[CW-1:0]) * CAW'(GRID_DIM) + CAW'(iz[CW-1:0]));
    own_addr = CAW'(CAW'(cx) * CAW'(GRID_DIM * GRID_DIM)
             + CAW'(cy) * CAW'(GRID_DIM) + CAW'(cz));
    scan_last = (ox == OW'(SPAN - 1)) && (oy == OW'(SPAN - 1)) && (oz == OW'(SPAN - 1));
    cell_hit  = (cell_rdata != '0);
    hit_index = cell_rdata - CNT_W'(1);
    no_parent = (active >= count);
    full      = (count >= CNT_W'(STORE_DEPTH));
    st_x = pt_rdata[PW-1 -: COORD_W];
    st_y = pt_rdata[2*COORD_W-1 -: COORD_W];
    st_z = pt_rdata[COORD_W-1:0];
    d_x  = {st_x[COORD_W-1], st_x} - {ax_info.pos[COORD_W-1], ax_info.pos};
    d_y  = {st_y[COORD_W-1], st_y} - {ay_info.pos[COORD_W-1], ay_info.pos};
    d_z  = {st_z[COORD_W-1], st_z} - {az_info.pos[COORD_W-1], az_info.pos};
    m_x  = d_x[COORD_W] ? (COORD_W+1)'(-d_x) : (COORD_W+1)'(d_x);
    m_y  = d_y[COORD_W] ? (COORD_W+1)'(-d_y) : (COORD_W+1)'(d_y);
    m_z  = d_z[COORD_W] ? (COORD_W+1)'(-d_z) : (COORD_W+1)'(d_z);
    dsum = (2*COORD_W+2)'(sq_x) + (2*COORD_W+2)'(sq_y) + (2*COORD_W+2)'(sq_z);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep == CAW'(CELLS - 1)) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (kind_t'(kind))
            KIND_CLEAR:   state_next = S_SWEEP;
            KIND_SEED:    state_next = S_AXIS0;
            KIND_CAND:    state_next = no_parent ? S_DONE : S_PARENT;
            KIND_ADVANCE: state_next = S_DONE;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_PARENT: state_next = S_AXIS0;
      S_AXIS0:  state_next = S_AXIS1;
      S_AXIS1:  state_next = S_EVAL;
      S_EVAL: begin
        if (!(ax_info.in_range && ay_info.in_range && az_info.in_range)) begin
          state_next = S_DONE;
        end else if (kind_q == KIND_SEED) begin
          state_next = S_OWN_RD;
        end else begin
          state_next = S_SCAN_ADDR;
        end
      end
      S_SCAN_ADDR: begin
        if (nb_ok) begin
          state_next = S_SCAN_CELL;
        end else if (scan_last) begin
          state_next = S_OWN_RD;
        end
      end
      S_SCAN_CELL: begin
        if (cell_hit) begin
          state_next = S_SCAN_PT;
        end else begin
          state_next = scan_last ? S_OWN_RD : S_SCAN_ADDR;
        end
      end
      S_SCAN_PT: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (dsum <= (2*COORD_W+2)'(r2)) begin
          state_next = S_DONE;
        end else begin
          state_next = scan_last ? S_OWN_RD : S_SCAN_ADDR;
        end
      end
      S_OWN_RD:  state_next = S_OWN_CHK;
      S_OWN_CHK: state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = own_addr;
    cell_wdata = count + CNT_W'(1);
    cell_raddr = nb_addr;
    pt_we      = 1'b0;
    pt_waddr   = count[PT_AW-1:0];
    pt_wdata   = {ax_info.pos, ay_info.pos, az_info.pos};
    pt_raddr   = active[PT_AW-1:0];
    unique case (state)
      S_SWEEP: begin
        cell_we    = 1'b1;
        cell_waddr = sweep;
        cell_wdata = '0;
      end
      S_SCAN_CELL: pt_raddr = hit_index[PT_AW-1:0];
      S_OWN_RD:    cell_raddr = own_addr;
      S_OWN_CHK: begin
        cell_we = !cell_hit && !full;
        pt_we   = !cell_hit && !full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      clr_reply <= 1'b0;
      sweep     <= '0;
      count     <= '0;
      active    <= '0;
      kind_q    <= KIND_CLEAR;
    end else begin
      state <= state_next;
      unique case (state)
        S_SWEEP: sweep <= sweep + CAW'(1);
        S_IDLE: begin
          if (start) begin
            kind_q <= kind_t'(kind);
            if (kind_t'(kind) == KIND_CLEAR) begin
              clr_reply <= 1'b1;
              sweep     <= '0;
              count     <= '0;
              active    <= '0;
            end else if (kind_t'(kind) == KIND_ADVANCE && !no_parent) begin
              active <= active + CNT_W'(1);
            end
          end
        end
        S_OWN_CHK: begin
          if (!cell_hit && !full) begin
            count <= count + CNT_W'(1);
          end
        end
        S_DONE: clr_reply <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        off_x      <= coord_x;
        off_y      <= coord_y;
        off_z      <= coord_z;
        p_x        <= coord_x;
        p_y        <= coord_y;
        p_z        <= coord_z;
        res_status <= ((kind_t'(kind) == KIND_CAND || kind_t'(kind) == KIND_ADVANCE) &&
                       no_parent) ? ST_NO_PARENT : ST_OK;
        res_index  <= '0;
        res_x      <= '0;
        res_y      <= '0;
        res_z      <= '0;
        ox         <= '0;
        oy         <= '0;
        oz         <= '0;
      end
      S_PARENT: begin
        p_x <= sat_add(st_x, off_x);
        p_y <= sat_add(st_y, off_y);
        p_z <= sat_add(st_z, off_z);
      end
      S_EVAL: begin
        res_x <= ax_info.pos;
        res_y <= ay_info.pos;
        res_z <= az_info.pos;
        if (!(ax_info.in_range && ay_info.in_range && az_info.in_range)) begin
          res_status <= ST_OUTSIDE;
        end
      end
      S_SCAN_PT: begin
        sq_x <= (2*COORD_W)'(m_x[COORD_W-1:0]) * (2*COORD_W)'(m_x[COORD_W-1:0]);
        sq_y <= (2*COORD_W)'(m_y[COORD_W-1:0]) * (2*COORD_W)'(m_y[COORD_W-1:0]);
        sq_z <= (2*COORD_W)'(m_z[COORD_W-1:0]) * (2*COORD_W)'(m_z[COORD_W-1:0]);
      end
      S_SCAN_CMP: begin
        if (dsum <= (2*COORD_W+2)'(r2)) begin
          res_status <= ST_TOO_CLOSE;
        end
      end
      S_OWN_CHK: begin
        if (cell_hit || full) begin
          res_status <= ST_TAKEN;
        end else begin
          res_index <= count[PT_AW-1:0];
        end
      end
      default: ;
    endcase
    if ((state == S_SCAN_ADDR && !nb_ok) || (state == S_SCAN_CELL && !cell_hit) ||
        state == S_SCAN_CMP) begin
      if (oz != OW'(SPAN - 1)) begin
        oz <= oz + OW'(1);
      end else begin
        oz <= '0;
        if (oy != OW'(SPAN - 1)) begin
          oy <= oy + OW'(1);
        end else begin
          oy <= '0;
          ox <= ox + OW'(1);
        end
      end
    end
  end

  always_comb begin
    busy        = (state != S_IDLE);
    done        = (state == S_DONE);
    status      = res_status;
    point_index = res_index;
    pos_x       = res_x;
    pos_y       = res_y;
    pos_z       = res_z;
    point_total = count;
  end

  `PDGS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(STORE_DEPTH))
  `PDGS_ASSERT_NOW(a_active_bound, clk, rst, 1'b1, active <= count)
  `PDGS_ASSERT_NEXT(a_clear_sweeps, clk, rst,
    start && !busy && kind == KIND_CLEAR, state == S_SWEEP && count == '0)
  `PDGS_ASSERT_NEXT(a_store_grows, clk, rst,
    state == S_OWN_CHK && !cell_hit && !full, count == $past(count) + CNT_W'(1))

endmodule
